// ----- design/vfa_pkg.sv -----
`timescale 1ns / 1ps
package vfa_pkg;

  localparam int CW     = 32;          // bits per component
  localparam int FB     = 16;          // fraction bits
  localparam int LANES  = 4;
  localparam int PROD_W = 2 * CW;      // one signed product
  localparam int SUM_W  = 2 * CW + 2;  // sum of four products
  localparam int SQ_W   = 2 * CW + 1;  // sum of squares, unsigned
  localparam int ROOT_W = CW + 1;      // floor sqrt of the sum of squares
  localparam int DREM_W = CW + FB;     // dividend of one normalize lane
  localparam int Q_W    = FB + 1;      // normalize quotient bits
  localparam int NORM_STAGES = ROOT_W + Q_W;

  typedef enum logic [2:0] {
    OP_ADD       = 3'd0,
    OP_SUB       = 3'd1,
    OP_SCALE     = 3'd2,
    OP_DOT       = 3'd3,
    OP_NORM      = 3'd4,
    OP_NORMALIZE = 3'd5,
    OP_EQUAL     = 3'd6
  } op_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  typedef struct packed {
    logic [2:0]           operation;
    logic signed [CW-1:0] a_x;
    logic signed [CW-1:0] a_y;
    logic signed [CW-1:0] a_z;
    logic signed [CW-1:0] a_w;
    logic signed [CW-1:0] b_x;
    logic signed [CW-1:0] b_y;
    logic signed [CW-1:0] b_z;
    logic signed [CW-1:0] b_w;
    logic signed [CW-1:0] scale_factor;
  } in_t;

  typedef struct packed {
    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic signed [CW-1:0] r_z;
    logic signed [CW-1:0] r_w;
    logic signed [CW-1:0] r_scalar;
    logic                 is_equal;
    logic [1:0]           status;
  } out_t;

  // per-lane result of the multiply stage
  typedef struct packed {
    logic signed [PROD_W-1:0] prod;
    logic [CW-1:0]            addsub;
    logic                     ovf;
    logic                     eq;
    logic [CW-1:0]            mag;
    logic                     neg;
  } lane_t;

  typedef struct packed {
    logic [ROOT_W-1:0] root;
    logic [SQ_W-1:0]   rem;
  } sq_step_t;

  typedef struct packed {
    logic [Q_W-1:0]    q;
    logic [DREM_W-1:0] rem;
  } div_step_t;

  // one bit of a restoring square root, rem holds sq - root^2
  function automatic sq_step_t sqrt_step(input logic [ROOT_W-1:0] root,
                                         input logic [SQ_W-1:0] rem, input int k);
    logic [SQ_W:0] trial;
    sq_step_t      r;
    trial = ({{(SQ_W + 1 - ROOT_W){1'b0}}, root} << (k + 1))
          + ((SQ_W + 1)'(1) << (2 * k));
    r.root = root;
    r.rem  = rem;
    if (trial <= {1'b0, rem}) begin
      r.root = root | (ROOT_W'(1) << k);
      r.rem  = rem - trial[SQ_W-1:0];
    end
    return r;
  endfunction

  // one bit of a restoring division by the root
  function automatic div_step_t div_step(input logic [Q_W-1:0] q,
                                         input logic [DREM_W-1:0] rem,
                                         input logic [ROOT_W-1:0] root, input int k);
    logic [DREM_W+1:0] dv;
    div_step_t         r;
    dv = {{(DREM_W + 2 - ROOT_W){1'b0}}, root} << k;
    r.q   = q;
    r.rem = rem;
    if (dv <= {2'b00, rem}) begin
      r.q   = q | (Q_W'(1) << k);
      r.rem = rem - dv[DREM_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- design/vfa_lane.sv -----
`timescale 1ns / 1ps
module vfa_lane (
  input  logic                          clk,
  input  vfa_pkg::op_t                  op,
  input  logic signed [vfa_pkg::CW-1:0] a,
  input  logic signed [vfa_pkg::CW-1:0] b,
  input  logic signed [vfa_pkg::CW-1:0] s,
  output vfa_pkg::lane_t                lane_r
);

  logic signed [vfa_pkg::CW-1:0] mop;
  logic signed [vfa_pkg::CW:0]   as_sum;
  vfa_pkg::lane_t                lane_nxt;

  always_comb begin
    // scale uses the scalar, dot uses b, norm and normalize square a
    if (op == vfa_pkg::OP_SCALE) begin
      mop = s;
    end else if (op == vfa_pkg::OP_DOT) begin
      mop = b;
    end else begin
      mop = a;
    end
    if (op == vfa_pkg::OP_SUB) begin
      as_sum = {a[vfa_pkg::CW-1], a} - {b[vfa_pkg::CW-1], b};
    end else begin
      as_sum = {a[vfa_pkg::CW-1], a} + {b[vfa_pkg::CW-1], b};
    end
    lane_nxt.prod = a * mop;
    lane_nxt.ovf  = as_sum[vfa_pkg::CW] != as_sum[vfa_pkg::CW-1];
    if (!lane_nxt.ovf) begin
      lane_nxt.addsub = as_sum[vfa_pkg::CW-1:0];
    end else if (as_sum[vfa_pkg::CW]) begin
      lane_nxt.addsub = {1'b1, {(vfa_pkg::CW - 1){1'b0}}};
    end else begin
      lane_nxt.addsub = {1'b0, {(vfa_pkg::CW - 1){1'b1}}};
    end
    lane_nxt.eq  = a == b;
    lane_nxt.neg = a[vfa_pkg::CW-1];
    lane_nxt.mag = a[vfa_pkg::CW-1] ? -a : a;
  end

  always_ff @(posedge clk) begin
    lane_r <= lane_nxt;
  end

endmodule

// ----- design/vfa_norm.sv -----
`timescale 1ns / 1ps
module vfa_norm (
  input  logic                                            clk,
  input  logic [vfa_pkg::SQ_W-1:0]                        sq,
  input  logic [vfa_pkg::LANES-1:0][vfa_pkg::CW-1:0]      mag,
  output logic [vfa_pkg::ROOT_W-1:0]                      root,
  output logic [vfa_pkg::LANES-1:0][vfa_pkg::Q_W-1:0]     quot
);

  localparam int RS = vfa_pkg::ROOT_W;
  localparam int DS = vfa_pkg::Q_W;

  logic [vfa_pkg::ROOT_W-1:0]                   root_r [RS];
  logic [vfa_pkg::SQ_W-1:0]                     srem_r [RS];
  logic [vfa_pkg::LANES-1:0][vfa_pkg::CW-1:0]   smag_r [RS];

  logic [vfa_pkg::ROOT_W-1:0]                   droot_r [DS];
  logic [vfa_pkg::LANES-1:0][vfa_pkg::Q_W-1:0]  q_r     [DS];
  logic [vfa_pkg::LANES-1:0][vfa_pkg::DREM_W-1:0] drem_r [DS];

  genvar g, l;
  generate
    // square root, one result bit per stage from the top
    for (g = 0; g < RS; g++) begin : g_sqrt
      vfa_pkg::sq_step_t st;
      if (g == 0) begin : g_first
        always_comb st = vfa_pkg::sqrt_step('0, sq, RS - 1);
        always_ff @(posedge clk) smag_r[g] <= mag;
      end else begin : g_next
        always_comb st = vfa_pkg::sqrt_step(root_r[g-1], srem_r[g-1], RS - 1 - g);
        always_ff @(posedge clk) smag_r[g] <= smag_r[g-1];
      end
      always_ff @(posedge clk) begin
        root_r[g] <= st.root;
        srem_r[g] <= st.rem;
      end
    end

    // four divisions side by side, one quotient bit per stage
    for (g = 0; g < DS; g++) begin : g_div
      if (g == 0) begin : g_first
        always_ff @(posedge clk) droot_r[g] <= root_r[RS-1];
      end else begin : g_next
        always_ff @(posedge clk) droot_r[g] <= droot_r[g-1];
      end
      for (l = 0; l < vfa_pkg::LANES; l++) begin : g_lane
        vfa_pkg::div_step_t st;
        if (g == 0) begin : g_first
          always_comb st = vfa_pkg::div_step('0,
              {smag_r[RS-1][l], {vfa_pkg::FB{1'b0}}}, root_r[RS-1], DS - 1);
        end else begin : g_next
          always_comb st = vfa_pkg::div_step(q_r[g-1][l], drem_r[g-1][l],
                                             droot_r[g-1], DS - 1 - g);
        end
        always_ff @(posedge clk) begin
          q_r[g][l]    <= st.q;
          drem_r[g][l] <= st.rem;
        end
      end
    end
  endgenerate

  assign root = droot_r[DS-1];
  assign quot = q_r[DS-1];

endmodule

// ----- design/vec4_fixed_point_alu_unit.sv -----
`timescale 1ns / 1ps
// path: an item reaches out_valid through 53 register stages
// (multiply, sum, 33 square root, 17 divide, output register)
// throughput: one item per cycle, busy is always low; every item takes the full path
// reset: synchronous active-low rst_n clears all valid flags, no result strobes after it
// the receiver cannot stall: each result is shown for exactly one cycle
module vec4_fixed_point_alu_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  vfa_pkg::in_t   in_item,
  output logic           out_valid,
  output vfa_pkg::out_t  out_item
);

  localparam int NS = vfa_pkg::NORM_STAGES;

  // side data carried alongside the norm pipeline
  typedef struct packed {
    vfa_pkg::op_t                                 op;
    logic [vfa_pkg::LANES-1:0][vfa_pkg::CW-1:0]   vec;
    logic [vfa_pkg::CW-1:0]                       dotv;
    logic                                         sat;
    logic                                         eq;
    logic [vfa_pkg::LANES-1:0]                    neg;
  } side_t;

  vfa_pkg::op_t                                   op_in;
  logic signed [vfa_pkg::LANES-1:0][vfa_pkg::CW-1:0] a_in, b_in;
  vfa_pkg::lane_t                                 lane_r [vfa_pkg::LANES];
  vfa_pkg::op_t                                   op1_r;
  logic                                           v1_r;

  // stage 2 registers
  logic [vfa_pkg::SQ_W-1:0]                       sq_r;
  logic [vfa_pkg::LANES-1:0][vfa_pkg::CW-1:0]     mag2_r;
  side_t                                          side_nxt;
  side_t                                          side_r [NS + 1];
  logic [NS:0]                                    v_r;

  logic signed [vfa_pkg::SUM_W-1:0]               dsum;
  logic [vfa_pkg::LANES-1:0][vfa_pkg::CW-1:0]     mag1;

  logic [vfa_pkg::ROOT_W-1:0]                     root;
  logic [vfa_pkg::LANES-1:0][vfa_pkg::Q_W-1:0]    quot;

  vfa_pkg::out_t                                  out_nxt, out_item_r;
  logic                                           out_valid_r;

  assign busy  = 1'b0;
  assign op_in = vfa_pkg::op_t'(in_item.operation);
  assign a_in  = {in_item.a_w, in_item.a_z, in_item.a_y, in_item.a_x};
  assign b_in  = {in_item.b_w, in_item.b_z, in_item.b_y, in_item.b_x};

  // stage 1: one multiplier and one adder per lane
  genvar l;
  generate
    for (l = 0; l < vfa_pkg::LANES; l++) begin : g_lane
      vfa_lane u_lane (
        .clk    (clk),
        .op     (op_in),
        .a      (a_in[l]),
        .b      (b_in[l]),
        .s      (in_item.scale_factor),
        .lane_r (lane_r[l])
      );
      assign mag1[l] = lane_r[l].mag;
    end
  endgenerate

  always_ff @(posedge clk) begin
    op1_r <= op_in;
  end

  // stage 2: merge lanes, sum of products, floor shift and saturate
  always_comb begin
    logic signed [vfa_pkg::PROD_W-vfa_pkg::FB-1:0] sh;
    logic signed [vfa_pkg::SUM_W-vfa_pkg::FB-1:0]  dsh;
    logic                                          ssat;
    dsum = '0;
    for (int i = 0; i < vfa_pkg::LANES; i++) begin
      dsum = dsum + vfa_pkg::SUM_W'(lane_r[i].prod);
    end
    side_nxt     = '0;
    side_nxt.op  = op1_r;
    side_nxt.eq  = 1'b1;
    ssat         = 1'b0;
    for (int i = 0; i < vfa_pkg::LANES; i++) begin
      side_nxt.eq     = side_nxt.eq & lane_r[i].eq;
      side_nxt.neg[i] = lane_r[i].neg;
      sh = lane_r[i].prod[vfa_pkg::PROD_W-1:vfa_pkg::FB];
      if (op1_r == vfa_pkg::OP_SCALE) begin
        if (sh > $signed((vfa_pkg::PROD_W-vfa_pkg::FB)'(
                 {1'b0, {(vfa_pkg::CW - 1){1'b1}}}))) begin
          side_nxt.vec[i] = {1'b0, {(vfa_pkg::CW - 1){1'b1}}};
          ssat = 1'b1;
        end else if (sh < $signed(-(vfa_pkg::PROD_W-vfa_pkg::FB)'(
                          {1'b1, {(vfa_pkg::CW - 1){1'b0}}}))) begin
          side_nxt.vec[i] = {1'b1, {(vfa_pkg::CW - 1){1'b0}}};
          ssat = 1'b1;
        end else begin
          side_nxt.vec[i] = sh[vfa_pkg::CW-1:0];
        end
      end else begin
        side_nxt.vec[i] = lane_r[i].addsub;
        ssat = ssat | lane_r[i].ovf;
      end
    end
    dsh = dsum[vfa_pkg::SUM_W-1:vfa_pkg::FB];
    if (dsh > $signed((vfa_pkg::SUM_W-vfa_pkg::FB)'(
              {1'b0, {(vfa_pkg::CW - 1){1'b1}}}))) begin
      side_nxt.dotv = {1'b0, {(vfa_pkg::CW - 1){1'b1}}};
      side_nxt.sat  = (op1_r == vfa_pkg::OP_DOT);
    end else if (dsh < $signed(-(vfa_pkg::SUM_W-vfa_pkg::FB)'(
                       {1'b1, {(vfa_pkg::CW - 1){1'b0}}}))) begin
      side_nxt.dotv = {1'b1, {(vfa_pkg::CW - 1){1'b0}}};
      side_nxt.sat  = (op1_r == vfa_pkg::OP_DOT);
    end else begin
      side_nxt.dotv = dsh[vfa_pkg::CW-1:0];
    end
    // add, subtract and scale report their own lane overflow
    if (op1_r == vfa_pkg::OP_ADD || op1_r == vfa_pkg::OP_SUB
        || op1_r == vfa_pkg::OP_SCALE) begin
      side_nxt.sat = ssat;
    end
  end

  always_ff @(posedge clk) begin
    // for norm ops each product is a square, so the sum is the sum of squares
    sq_r      <= dsum[vfa_pkg::SQ_W-1:0];
    mag2_r    <= mag1;
    side_r[0] <= side_nxt;
    for (int i = 1; i <= NS; i++) begin
      side_r[i] <= side_r[i-1];
    end
  end

  // square root and normalize pipeline, aligned with side_r[NS]
  vfa_norm u_norm (
    .clk  (clk),
    .sq   (sq_r),
    .mag  (mag2_r),
    .root (root),
    .quot (quot)
  );

  // final merge of lane results, dot product, norm, normalize and equality
  always_comb begin
    side_t s;
    logic [vfa_pkg::LANES-1:0][vfa_pkg::CW-1:0] rv;
    s        = side_r[NS];
    out_nxt  = '0;
    rv       = '0;
    case (s.op)
      vfa_pkg::OP_ADD, vfa_pkg::OP_SUB, vfa_pkg::OP_SCALE: begin
        rv = s.vec;
        out_nxt.status = s.sat ? vfa_pkg::ST_SAT : vfa_pkg::ST_OK;
      end
      vfa_pkg::OP_DOT: begin
        out_nxt.r_scalar = s.dotv;
        out_nxt.status   = s.sat ? vfa_pkg::ST_SAT : vfa_pkg::ST_OK;
      end
      vfa_pkg::OP_NORM: begin
        // root above the largest positive component clamps
        if (|root[vfa_pkg::ROOT_W-1:vfa_pkg::CW-1]) begin
          out_nxt.r_scalar = {1'b0, {(vfa_pkg::CW - 1){1'b1}}};
          out_nxt.status   = vfa_pkg::ST_SAT;
        end else begin
          out_nxt.r_scalar = root[vfa_pkg::CW-1:0];
        end
      end
      vfa_pkg::OP_NORMALIZE: begin
        if (root == '0) begin
          out_nxt.status = vfa_pkg::ST_ZERO;
        end else begin
          // quotient never exceeds one, so it cannot overflow a component
          for (int i = 0; i < vfa_pkg::LANES; i++) begin
            rv[i] = s.neg[i] ? -vfa_pkg::CW'(quot[i]) : vfa_pkg::CW'(quot[i]);
          end
        end
      end
      vfa_pkg::OP_EQUAL: begin
        out_nxt.is_equal = s.eq;
      end
      default: begin
        out_nxt = '0;
      end
    endcase
    out_nxt.r_x = rv[0];
    out_nxt.r_y = rv[1];
    out_nxt.r_z = rv[2];
    out_nxt.r_w = rv[3];
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= start;
      v_r         <= {v_r[NS-1:0], v1_r};
      out_valid_r <= v_r[NS];
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;

  localparam int LATENCY     = 53;
  localparam int N_RANDOM    = 1800;
  localparam int CYCLE_LIMIT = 200000;
  localparam int CW          = vfa_pkg::CW;
  localparam int FB          = vfa_pkg::FB;
  localparam int SUM_W       = vfa_pkg::SUM_W;
  localparam int SQ_W        = vfa_pkg::SQ_W;
  localparam int ROOT_W      = vfa_pkg::ROOT_W;
  localparam int DREM_W      = vfa_pkg::DREM_W;
  localparam logic [2:0] OP_UNUSED = 3'd7;

  logic          clk;
  logic          rst_n;
  logic          start;
  logic          busy;
  vfa_pkg::in_t  in_item;
  logic          out_valid;
  vfa_pkg::out_t out_item;

  vfa_pkg::out_t expected_q[$];
  int   mismatch_count;
  int   cycle_count;

  vec4_fixed_point_alu_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // saturate a wide signed value to one component
  function automatic logic [CW-1:0] clamp_component(input logic signed [SUM_W-1:0] v,
                                                    inout logic sat);
    logic signed [SUM_W-1:0] hi_lim;
    logic signed [SUM_W-1:0] lo_lim;
    hi_lim = (SUM_W'(1) <<< (CW - 1)) - 1;
    lo_lim = -(SUM_W'(1) <<< (CW - 1));
    if (v > hi_lim) begin
      sat = 1'b1;
      return hi_lim[CW-1:0];
    end
    if (v < lo_lim) begin
      sat = 1'b1;
      return lo_lim[CW-1:0];
    end
    return v[CW-1:0];
  endfunction

  // integer square root by bisection on bits, floor
  function automatic logic [ROOT_W-1:0] floor_sqrt(input logic [SQ_W-1:0] sq);
    logic [ROOT_W-1:0] root;
    logic [ROOT_W-1:0] cand;
    logic [2*ROOT_W-1:0] cand_sq;
    root = '0;
    for (int k = ROOT_W - 1; k >= 0; k--) begin
      cand    = root | (ROOT_W'(1) << k);
      cand_sq = (2*ROOT_W)'(cand) * (2*ROOT_W)'(cand);
      if (cand_sq <= (2*ROOT_W)'(sq)) root = cand;
    end
    return root;
  endfunction

  // predicts the one result of an item
  function automatic vfa_pkg::out_t vec_alu_result(input vfa_pkg::in_t it);
    vfa_pkg::out_t r;
    logic sat;
    logic signed [CW-1:0] a[4];
    logic signed [CW-1:0] b[4];
    logic signed [CW-1:0] rv[4];
    logic signed [SUM_W-1:0] acc;
    logic signed [SUM_W-1:0] prod;
    logic [SQ_W-1:0] sq;
    logic [ROOT_W-1:0] root;
    logic [CW-1:0] m;
    logic [DREM_W-1:0] dividend;
    logic [DREM_W-1:0] q;
    r   = '0;
    sat = 1'b0;
    a   = '{it.a_x, it.a_y, it.a_z, it.a_w};
    b   = '{it.b_x, it.b_y, it.b_z, it.b_w};
    rv  = '{default: '0};
    case (it.operation)
      vfa_pkg::OP_ADD, vfa_pkg::OP_SUB: begin
        for (int i = 0; i < 4; i++) begin
          acc = (it.operation == vfa_pkg::OP_ADD) ? SUM_W'(a[i]) + SUM_W'(b[i])
                                                  : SUM_W'(a[i]) - SUM_W'(b[i]);
          rv[i] = clamp_component(acc, sat);
        end
      end
      vfa_pkg::OP_SCALE: begin
        for (int i = 0; i < 4; i++) begin
          prod  = SUM_W'(a[i]) * SUM_W'(it.scale_factor);
          rv[i] = clamp_component(prod >>> FB, sat);
        end
      end
      vfa_pkg::OP_DOT: begin
        acc = '0;
        for (int i = 0; i < 4; i++) acc += SUM_W'(a[i]) * SUM_W'(b[i]);
        r.r_scalar = clamp_component(acc >>> FB, sat);
      end
      vfa_pkg::OP_NORM, vfa_pkg::OP_NORMALIZE: begin
        sq = '0;
        for (int i = 0; i < 4; i++) begin
          m  = a[i][CW-1] ? -a[i] : a[i];
          sq += SQ_W'(m) * SQ_W'(m);
        end
        root = floor_sqrt(sq);
        if (it.operation == vfa_pkg::OP_NORM) begin
          r.r_scalar = clamp_component(SUM_W'({1'b0, root}), sat);
        end else if (root == '0) begin
          r.status = vfa_pkg::ST_ZERO;
        end else begin
          for (int i = 0; i < 4; i++) begin
            m        = a[i][CW-1] ? -a[i] : a[i];
            dividend = DREM_W'(m) << FB;
            q        = dividend / DREM_W'(root);
            // quotient is small, negate for negative components
            rv[i] = clamp_component(a[i][CW-1] ? -SUM_W'(q) : SUM_W'(q), sat);
          end
        end
      end
      vfa_pkg::OP_EQUAL: begin
        r.is_equal = (a[0] == b[0]) && (a[1] == b[1]) && (a[2] == b[2])
                     && (a[3] == b[3]);
      end
      default: ;
    endcase
    r.r_x = rv[0];
    r.r_y = rv[1];
    r.r_z = rv[2];
    r.r_w = rv[3];
    if (sat && r.status == vfa_pkg::ST_OK) r.status = vfa_pkg::ST_SAT;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [CW-1:0] got,
                                 input logic [CW-1:0] want);
    mismatch_count++;
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
  endtask

  // check every strobed result against the oldest expectation
  always @(posedge clk) begin
    vfa_pkg::out_t want;
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", out_item.r_x, '0);
      end else begin
        want = expected_q.pop_front();
        if (out_item.r_x !== want.r_x) report_mismatch("r_x", out_item.r_x, want.r_x);
        if (out_item.r_y !== want.r_y) report_mismatch("r_y", out_item.r_y, want.r_y);
        if (out_item.r_z !== want.r_z) report_mismatch("r_z", out_item.r_z, want.r_z);
        if (out_item.r_w !== want.r_w) report_mismatch("r_w", out_item.r_w, want.r_w);
        if (out_item.r_scalar !== want.r_scalar)
          report_mismatch("r_scalar", out_item.r_scalar, want.r_scalar);
        if (out_item.is_equal !== want.is_equal)
          report_mismatch("is_equal", CW'(out_item.is_equal), CW'(want.is_equal));
        if (out_item.status !== want.status)
          report_mismatch("status", CW'(out_item.status), CW'(want.status));
      end
    end
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("vec4_fixed_point_alu_unit test failed");
      $finish;
    end
  end

  // sends one item, holds start until the block takes it
  task automatic send_item(input vfa_pkg::in_t it, input bit keep_start);
    in_item = it;
    start   = 1'b1;
    do @(posedge clk); while (busy);
    expected_q.push_back(vec_alu_result(it));
    @(negedge clk);
    if (!keep_start) start = 1'b0;
  endtask

  // random component biased toward extremes and small values
  function automatic logic [CW-1:0] rand_component();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return CW'($signed($urandom_range(0, 8'hff)) - 128);
      3: return CW'($signed($urandom_range(0, 20'hfffff)) - 20'sh80000);
      4: return '0;
      default: return $urandom();
    endcase
  endfunction

  function automatic vfa_pkg::in_t rand_item();
    vfa_pkg::in_t it;
    it.operation = 3'($urandom_range(0, 7));
    it.a_x = rand_component();
    it.a_y = rand_component();
    it.a_z = rand_component();
    it.a_w = rand_component();
    // equal vectors are rare at random, so copy A into B now and then
    if ($urandom_range(0, 3) == 0) begin
      it.b_x = it.a_x;
      it.b_y = it.a_y;
      it.b_z = it.a_z;
      it.b_w = it.a_w;
      if ($urandom_range(0, 1)) it.b_w = it.b_w ^ (CW'(1) << $urandom_range(0, CW - 1));
    end else begin
      it.b_x = rand_component();
      it.b_y = rand_component();
      it.b_z = rand_component();
      it.b_w = rand_component();
    end
    it.scale_factor = rand_component();
    return it;
  endfunction

  // directed table
  localparam int N_DIRECTED = 18;
  typedef struct {
    logic [2:0]  op;
    logic [31:0] ax, ay, az, aw, bx, by, bz, bw, sf;
  } dir_row_t;
  dir_row_t dir_rows[N_DIRECTED];

  initial begin
    // add and subtract saturation at both ends
    dir_rows[0]  = '{vfa_pkg::OP_ADD, 32'h7fffffff, 32'h80000000, 32'h00010000, 32'h0,
                     32'h00000001, 32'hffffffff, 32'h00010000, 32'h0, 32'h0};
    dir_rows[1]  = '{vfa_pkg::OP_SUB, 32'h80000000, 32'h7fffffff, 32'h00020000,
                     32'hffffffff, 32'h00000001, 32'hffffffff, 32'h00010000,
                     32'hffffffff, 32'h0};
    dir_rows[2]  = '{vfa_pkg::OP_ADD, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                     32'h0, 32'h0};
    // scale: unity, negative, overflow, floor rounding
    dir_rows[3]  = '{vfa_pkg::OP_SCALE, 32'h00010000, 32'hffff0000, 32'h7fffffff,
                     32'h80000000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h00010000};
    dir_rows[4]  = '{vfa_pkg::OP_SCALE, 32'h7fffffff, 32'h80000000, 32'h00000001,
                     32'hffffffff, 32'h0, 32'h0, 32'h0, 32'h0, 32'h80000000};
    dir_rows[5]  = '{vfa_pkg::OP_SCALE, 32'h00000003, 32'hfffffffd, 32'h00018000,
                     32'h12345678, 32'h0, 32'h0, 32'h0, 32'h0, 32'h00008000};
    // dot: small, overflow both signs, min times min
    dir_rows[6]  = '{vfa_pkg::OP_DOT, 32'h00010000, 32'h00020000, 32'h00030000,
                     32'h00040000, 32'h00010000, 32'h00010000, 32'h00010000,
                     32'h00010000, 32'h0};
    dir_rows[7]  = '{vfa_pkg::OP_DOT, 32'h80000000, 32'h80000000, 32'h80000000,
                     32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                     32'h80000000, 32'h0};
    dir_rows[8]  = '{vfa_pkg::OP_DOT, 32'h7fffffff, 32'h7fffffff, 32'h0, 32'h0,
                     32'h80000000, 32'h80000000, 32'h0, 32'h0, 32'h0};
    dir_rows[9]  = '{vfa_pkg::OP_DOT, 32'hffffffff, 32'h0, 32'h0, 32'h0, 32'h00000001,
                     32'h0, 32'h0, 32'h0, 32'h0};
    // norm: 3-4-5, largest, zero
    dir_rows[10] = '{vfa_pkg::OP_NORM, 32'h00030000, 32'hfffc0000, 32'h0, 32'h0,
                     32'h0, 32'h0, 32'h0, 32'h0, 32'h0};
    dir_rows[11] = '{vfa_pkg::OP_NORM, 32'h80000000, 32'h80000000, 32'h80000000,
                     32'h80000000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0};
    dir_rows[12] = '{vfa_pkg::OP_NORM, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                     32'h0, 32'h0};
    // normalize: zero vector, single axis, tiny and extreme components together
    dir_rows[13] = '{vfa_pkg::OP_NORMALIZE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                     32'h0, 32'h0, 32'h0};
    dir_rows[14] = '{vfa_pkg::OP_NORMALIZE, 32'hfff00000, 32'h0, 32'h0, 32'h0, 32'h0,
                     32'h0, 32'h0, 32'h0, 32'h0};
    dir_rows[15] = '{vfa_pkg::OP_NORMALIZE, 32'h00000001, 32'hffffffff, 32'h80000000,
                     32'h7fffffff, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0};
    // equality and the unused code
    dir_rows[16] = '{vfa_pkg::OP_EQUAL, 32'h80000000, 32'h7fffffff, 32'h5, 32'h6,
                     32'h80000000, 32'h7fffffff, 32'h5, 32'h6, 32'h0};
    dir_rows[17] = '{OP_UNUSED, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                     32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                     32'hffffffff};
  end

  // expected values typed in where they read off at a glance
  task automatic check_typed(input int row, input vfa_pkg::out_t want);
    vfa_pkg::out_t pred;
    pred = vec_alu_result(in_item);
    if (pred !== want) report_mismatch($sformatf("table row %0d", row), pred[CW-1:0],
                                       want[CW-1:0]);
  endtask

  initial begin
    vfa_pkg::in_t  it;
    vfa_pkg::out_t typed;
    int    burst;
    int    sent;
    mismatch_count = 0;
    cycle_count    = 0;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part
    for (int i = 0; i < N_DIRECTED; i++) begin
      it.operation    = dir_rows[i].op;
      it.a_x          = dir_rows[i].ax;
      it.a_y          = dir_rows[i].ay;
      it.a_z          = dir_rows[i].az;
      it.a_w          = dir_rows[i].aw;
      it.b_x          = dir_rows[i].bx;
      it.b_y          = dir_rows[i].by;
      it.b_z          = dir_rows[i].bz;
      it.b_w          = dir_rows[i].bw;
      it.scale_factor = dir_rows[i].sf;
      in_item = it;
      typed   = '0;
      case (i)
        0: begin
          typed.r_x = 32'h7fffffff; typed.r_y = 32'h80000000;
          typed.r_z = 32'h00020000; typed.status = vfa_pkg::ST_SAT;
        end
        2, 17: check_typed(i, typed);
        7: begin typed.r_scalar = 32'h7fffffff; typed.status = vfa_pkg::ST_SAT; end
        10: typed.r_scalar = 32'h00050000;
        12: typed.r_scalar = '0;
        13: typed.status = vfa_pkg::ST_ZERO;
        16: typed.is_equal = 1'b1;
        default: typed = vec_alu_result(it);
      endcase
      if (i inside {0, 7, 10, 12, 13, 16}) check_typed(i, typed);
      send_item(it, i != N_DIRECTED - 1);
    end

    // drain fully once before the random part
    while (expected_q.size() != 0) @(negedge clk);

    // random part in bursts with random gaps
    sent = 0;
    while (sent < N_RANDOM) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8);
      for (int j = 0; j < burst && sent < N_RANDOM; j++) begin
        send_item(rand_item(), j != burst - 1 && sent != N_RANDOM - 1);
        sent++;
      end
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 60)) @(negedge clk);
      // occasionally let the pipeline empty completely
      if ($urandom_range(0, 40) == 0)
        while (expected_q.size() != 0) @(negedge clk);
    end
    start = 1'b0;

    while (expected_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("vec4_fixed_point_alu_unit test passed");
    end else begin
      $display("vec4_fixed_point_alu_unit test failed");
    end
    $finish;
  end

endmodule
